### hdl/sphere_triangle_index_generator_unit_defines.svh
// Assertion helpers for the sphere index generator.
// STIG_ASSERT expects the enclosing module to have clk and rst_n; STIG_ASSERT_ALWAYS needs only clk.
`ifndef SPHERE_TRIANGLE_INDEX_GENERATOR_UNIT_DEFINES_SVH
`define SPHERE_TRIANGLE_INDEX_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define STIG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stig assertion failed");
`define STIG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stig assertion failed");
`else
`define STIG_ASSERT(lbl, prop)
`define STIG_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### hdl/stig_pkg.sv
package stig_pkg;

  localparam int IDX_W       = 20;
  localparam int CNT_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] MIN_SLICES = CNT_W'(3);
  localparam logic [CNT_W-1:0] MIN_STACKS = CNT_W'(2);
  localparam logic [CNT_W-1:0] RST_SLICES = CNT_W'(20);
  localparam logic [CNT_W-1:0] RST_STACKS = CNT_W'(20);

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    PH_TOP,
    PH_QUAD,
    PH_BOTTOM
  } stig_phase_t;

  typedef enum logic [1:0] {
    K_TOP,
    K_QUAD_LO,
    K_QUAD_HI,
    K_BOTTOM
  } stig_kind_t;

  // clamped geometry
  typedef struct packed {
    logic [CNT_W-1:0] slices;
    logic [CNT_W-1:0] stacks;
  } stig_geom_t;

  // one triangle, classified by the sequencer
  typedef struct packed {
    stig_kind_t       kind;
    logic [CNT_W-1:0] slice;
    logic [IDX_W-1:0] ring_base;
    logic             last;
  } stig_desc_t;

endpackage

### hdl/sphere_triangle_index_generator_unit.sv
// UV sphere triangle-list index generator.
// Input side is a queue: drive in_restart and raise push while full is low;
// each transaction asks for the next triangle (in_restart = 1 starts over at
// the first triangle of the top cap).
// Result side is a queue: while empty is low the oldest triangle sits on
// out_first_vertex/out_second_vertex/out_third_vertex/out_last_triangle and
// is taken by pop. out_last_triangle marks the final bottom-cap triangle;
// the sequence then wraps to the top cap.
// Throughput is one triangle per cycle in both directions while neither
// side stalls. A result goes from the sequencer through the four-entry
// queue and the index adders into the output register. A stalled receiver
// fills the output register and then the four-entry queue; full rises
// after that and the sequencer holds its position. The user must write
// config (cfg_we/cfg_index/cfg_wdata) only while no triangle is in flight
// (the block does not enforce this); slice_count below 3 acts as 3,
// stack_count below 2 acts as 2. Reset (rst_n low, synchronous) sets both
// counts to 20, empties the queue and points the sequencer at the first triangle.
module sphere_triangle_index_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic                            in_restart,
  output logic                            empty,
  input  logic                            pop,
  output logic [stig_pkg::IDX_W-1:0]      out_first_vertex,
  output logic [stig_pkg::IDX_W-1:0]      out_second_vertex,
  output logic [stig_pkg::IDX_W-1:0]      out_third_vertex,
  output logic                            out_last_triangle,
  input  logic                            cfg_we,
  input  logic [stig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stig_pkg::CNT_W-1:0]      cfg_wdata
);
  import stig_pkg::*;

  logic [CNT_W-1:0] slice_count_r, stack_count_r;
  stig_geom_t       geom;
  stig_desc_t       f_desc, q_desc;
  logic             accept, q_rd, q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_count_r <= RST_SLICES;
      stack_count_r <= RST_STACKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLICE_COUNT: slice_count_r <= cfg_wdata;
        REG_STACK_COUNT: stack_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign geom.slices = (slice_count_r < MIN_SLICES) ? MIN_SLICES : slice_count_r;
  assign geom.stacks = (stack_count_r < MIN_STACKS) ? MIN_STACKS : stack_count_r;

  assign accept = push && !full;

  stig_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .accept  (accept),
    .restart (in_restart),
    .desc    (f_desc)
  );

  stig_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_data   (f_desc),
    .full      (full),
    .rd_en     (q_rd),
    .rd_data   (q_desc),
    .not_empty (q_not_empty)
  );

  stig_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .geom          (geom),
    .q_not_empty   (q_not_empty),
    .q_data        (q_desc),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .first_vertex  (out_first_vertex),
    .second_vertex (out_second_vertex),
    .third_vertex  (out_third_vertex),
    .last_triangle (out_last_triangle)
  );

endmodule

### hdl/stig_front.sv
`include "sphere_triangle_index_generator_unit_defines.svh"

module stig_front (
  input  logic                clk,
  input  logic                rst_n,
  input  stig_pkg::stig_geom_t geom,
  input  logic                accept,
  input  logic                restart,
  output stig_pkg::stig_desc_t desc
);
  import stig_pkg::*;

  stig_phase_t      phase_r, phase_nxt, eff_phase;
  logic [CNT_W-1:0] slice_r, slice_nxt, eff_slice;
  logic [CNT_W-1:0] ring_r, ring_nxt, eff_ring;
  logic             half_r, half_nxt, eff_half;
  logic [IDX_W-1:0] base_r, base_nxt, eff_base;
  logic             slice_end, ring_end;
  logic [IDX_W-1:0] ring_size;

  assign eff_phase = restart ? PH_TOP : phase_r;
  assign eff_slice = restart ? '0 : slice_r;
  assign eff_ring  = restart ? '0 : ring_r;
  assign eff_half  = restart ? 1'b0 : half_r;
  assign eff_base  = restart ? IDX_W'(1) : base_r;

  assign slice_end = ({1'b0, eff_slice} + (CNT_W+1)'(1)) >= {1'b0, geom.slices};
  assign ring_end  = ({1'b0, eff_ring} + (CNT_W+1)'(1)) >=
                     ({1'b0, geom.stacks} - (CNT_W+1)'(2));
  assign ring_size = IDX_W'(geom.slices) + IDX_W'(1);

  // next state
  always_comb begin
    phase_nxt = eff_phase;
    slice_nxt = eff_slice;
    ring_nxt  = eff_ring;
    half_nxt  = eff_half;
    base_nxt  = eff_base;
    unique case (eff_phase)
      PH_TOP: begin
        if (slice_end) begin
          slice_nxt = '0;
          half_nxt  = 1'b0;
          ring_nxt  = '0;
          base_nxt  = IDX_W'(1);
          phase_nxt = (geom.stacks > MIN_STACKS) ? PH_QUAD : PH_BOTTOM;
        end else begin
          slice_nxt = eff_slice + CNT_W'(1);
        end
      end
      PH_QUAD: begin
        if (!eff_half) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          if (slice_end) begin
            slice_nxt = '0;
            if (ring_end) begin
              phase_nxt = PH_BOTTOM;
            end else begin
              ring_nxt = eff_ring + CNT_W'(1);
              base_nxt = eff_base + ring_size;
            end
          end else begin
            slice_nxt = eff_slice + CNT_W'(1);
          end
        end
      end
      default: begin
        if (slice_end) begin
          phase_nxt = PH_TOP;
          slice_nxt = '0;
          ring_nxt  = '0;
          half_nxt  = 1'b0;
          base_nxt  = IDX_W'(1);
        end else begin
          slice_nxt = eff_slice + CNT_W'(1);
        end
      end
    endcase
  end

  // descriptor
  always_comb begin
    desc.slice     = eff_slice;
    desc.ring_base = eff_base;
    desc.last      = 1'b0;
    unique case (eff_phase)
      PH_TOP:  desc.kind = K_TOP;
      PH_QUAD: desc.kind = eff_half ? K_QUAD_HI : K_QUAD_LO;
      default: begin
        desc.kind = K_BOTTOM;
        desc.last = slice_end;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOP;
      slice_r <= '0;
      ring_r  <= '0;
      half_r  <= 1'b0;
      base_r  <= IDX_W'(1);
    end else if (accept) begin
      phase_r <= phase_nxt;
      slice_r <= slice_nxt;
      ring_r  <= ring_nxt;
      half_r  <= half_nxt;
      base_r  <= base_nxt;
    end
  end

  // second half of a quad only exists inside the quad phase
  `STIG_ASSERT_ALWAYS(a_half_in_quad, half_r |-> (phase_r == PH_QUAD))

endmodule

### hdl/stig_queue.sv
`include "sphere_triangle_index_generator_unit_defines.svh"

module stig_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  stig_pkg::stig_desc_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output stig_pkg::stig_desc_t rd_data,
  output logic                 not_empty
);
  import stig_pkg::*;

  stig_desc_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      // count holds when both or neither side moves
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  `STIG_ASSERT(a_no_overflow, !(wr_en && full))
  `STIG_ASSERT(a_no_underflow, !(rd_en && !not_empty))

endmodule

### hdl/stig_back.sv
`include "sphere_triangle_index_generator_unit_defines.svh"

module stig_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stig_pkg::stig_geom_t         geom,
  input  logic                         q_not_empty,
  input  stig_pkg::stig_desc_t         q_data,
  output logic                         q_rd,
  output logic                         empty,
  input  logic                         pop,
  output logic [stig_pkg::IDX_W-1:0]   first_vertex,
  output logic [stig_pkg::IDX_W-1:0]   second_vertex,
  output logic [stig_pkg::IDX_W-1:0]   third_vertex,
  output logic                         last_triangle
);
  import stig_pkg::*;

  logic [IDX_W-1:0]       south_r;
  logic [CNT_W:0]         ring_w;
  logic [2*CNT_W:0]       south_prod;
  logic [IDX_W-1:0]       ring_size, top, south_base, a_nxt, b_nxt, c_nxt;
  logic                   out_valid_r;
  logic [IDX_W-1:0]       a_r, b_r, c_r;
  logic                   last_r;

  // pole index follows config; the user must change config only while idle, the block does not enforce it
  assign ring_w     = {1'b0, geom.slices} + (CNT_W+1)'(1);
  assign south_prod = (2*CNT_W+1)'(geom.stacks - CNT_W'(1)) * (2*CNT_W+1)'(ring_w);

  always_ff @(posedge clk) begin
    south_r <= IDX_W'(south_prod) + IDX_W'(1);
  end

  assign ring_size  = IDX_W'(ring_w);
  assign top        = q_data.ring_base + IDX_W'(q_data.slice);
  assign south_base = south_r - ring_size + IDX_W'(q_data.slice);

  always_comb begin
    unique case (q_data.kind)
      K_TOP: begin
        a_nxt = '0;
        b_nxt = IDX_W'(q_data.slice) + IDX_W'(2);
        c_nxt = IDX_W'(q_data.slice) + IDX_W'(1);
      end
      K_QUAD_LO: begin
        a_nxt = top;
        b_nxt = top + IDX_W'(1);
        c_nxt = top + ring_size;
      end
      K_QUAD_HI: begin
        a_nxt = top + ring_size;
        b_nxt = top + IDX_W'(1);
        c_nxt = top + ring_size + IDX_W'(1);
      end
      default: begin
        a_nxt = south_r;
        b_nxt = south_base;
        c_nxt = south_base + IDX_W'(1);
      end
    endcase
  end

  assign q_rd  = q_not_empty && (!out_valid_r || pop);
  assign empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_rd) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      last_r <= q_data.last;
    end
  end

  assign first_vertex  = a_r;
  assign second_vertex = b_r;
  assign third_vertex  = c_r;
  assign last_triangle = last_r;

  `STIG_ASSERT(a_load_shows, q_rd |=> out_valid_r)

endmodule
